// File: hw/rtl/expression_char_lexer_macros.svh
// Assertion macros for the expression character lexer checker.
// Used by ecl_checker; expects clk_i and rst_ni in the enclosing scope.
`ifndef EXPRESSION_CHAR_LEXER_MACROS_SVH
`define EXPRESSION_CHAR_LEXER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define ECL_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define ECL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/ecl_pkg.sv
// Shared types and constants for the expression character lexer.
// No dependencies; imported by every lexer module.
`default_nettype none

package ecl_pkg;

  // Default bound on quote nesting inside a string literal.
  localparam int unsigned DefMaxQuoteDepth = 15;

  // Result bundles held between the lexer front and the output stage.
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned MaxResults = 4;

  // Characters with a special role in the grammar.
  localparam logic [7:0] CharDollar     = 8'h24;
  localparam logic [7:0] CharUnderscore = 8'h5f;
  localparam logic [7:0] CharDot        = 8'h2e;
  localparam logic [7:0] CharEq         = 8'h3d;
  localparam logic [7:0] CharSquote     = 8'h27;
  localparam logic [7:0] CharDquote     = 8'h22;

  typedef enum logic [2:0] {
    KindId   = 3'd0,
    KindNum  = 3'd1,
    KindOp   = 3'd2,
    KindStr  = 3'd3,
    KindNone = 3'd4
  } tok_kind_e;

  typedef enum logic [1:0] {
    ErrNone         = 2'd0,
    ErrSecondDot    = 2'd1,
    ErrUnterminated = 2'd2,
    ErrNestOverflow = 2'd3
  } err_e;

  typedef enum logic [2:0] {
    ModeIdle     = 3'd0,
    ModeIdFirst  = 3'd1,
    ModeIdMore   = 3'd2,
    ModeNumFirst = 3'd3,
    ModeNumMore  = 3'd4,
    ModeOp       = 3'd5,
    ModeStr      = 3'd6
  } lex_mode_e;

  // One result item as it leaves the block.
  typedef struct packed {
    logic [7:0] tok_char;
    tok_kind_e  tok_kind;
    logic       tok_first;
    logic       tok_last;
    err_e       err_code;
    logic       line_done;
  } item_t;

  // All result items caused by one input character.
  typedef struct packed {
    item_t [MaxResults-1:0]          items;
    logic [$clog2(MaxResults)-1:0]   last_idx;
  } bundle_t;

  // A bundle with its valid flag, used on both sides of the queue.
  typedef struct packed {
    logic    valid;
    bundle_t bundle;
  } bundle_req_t;

endpackage

`default_nettype wire

// File: hw/rtl/ecl_front.sv
// Lexer front: accepts characters, tracks token state, builds result bundles.
// Depends on ecl_pkg.
`default_nettype none

module ecl_front #(
  parameter int unsigned MaxQuoteDepth = ecl_pkg::DefMaxQuoteDepth
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [7:0]          ch_i,
  input  wire logic                line_end_i,
  input  wire logic                q_full_i,
  output ecl_pkg::bundle_req_t     push_o
);
  import ecl_pkg::*;

  localparam int unsigned DepthW = $clog2(MaxQuoteDepth + 1);
  localparam int unsigned NumW   = $clog2(MaxResults + 1);
  localparam int unsigned IdxW   = $clog2(MaxResults);

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_id_start(input logic [7:0] c);
    return (c inside {[8'h41:8'h5a], [8'h61:8'h7a]}) || c == CharUnderscore ||
           c == CharDollar;
  endfunction

  // Characters that combine with a following '=' into one operator.
  function automatic logic is_eq_op(input logic [7:0] c);
    return c inside {8'h2b, 8'h2d, 8'h2a, 8'h2f, 8'h25, 8'h5e,
                     8'h7c, 8'h26, 8'h3d, 8'h3c, 8'h3e, 8'h21};
  endfunction

  function automatic logic is_op(input logic [7:0] c);
    return is_eq_op(c) || (c inside {8'h7e, 8'h3b, 8'h2c, 8'h2e, 8'h28, 8'h29,
                                     8'h5b, 8'h5d, 8'h7b, 8'h7d});
  endfunction

  function automatic item_t mk_item(input logic [7:0] c, input tok_kind_e k,
                                    input logic first, input logic last,
                                    input err_e err);
    item_t it;
    it.tok_char  = c;
    it.tok_kind  = k;
    it.tok_first = first;
    it.tok_last  = last;
    it.err_code  = err;
    it.line_done = 1'b0;
    return it;
  endfunction

  lex_mode_e         mode_q, mode_d;
  logic [7:0]        held0_q, held0_d, held1_q, held1_d;
  logic [1:0]        cnt_q, cnt_d;
  logic              dot_q, dot_d;
  logic [DepthW-1:0] depth_q, depth_d;
  logic              oq_q, oq_d;
  logic              skip_q, skip_d;

  logic              accept;
  item_t [MaxResults-1:0] items;
  logic [NumW-1:0]   n;
  logic              do_start;
  logic              is_id;
  logic              first_f;
  tok_kind_e         kind;
  logic [7:0]        close_ch;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // Next token state and the result items for the current character.
  always_comb begin
    mode_d   = mode_q;
    held0_d  = held0_q;
    held1_d  = held1_q;
    cnt_d    = cnt_q;
    dot_d    = dot_q;
    depth_d  = depth_q;
    oq_d     = oq_q;
    skip_d   = skip_q;
    items    = '0;
    n        = '0;
    do_start = 1'b0;
    is_id    = (mode_q == ModeIdFirst) || (mode_q == ModeIdMore);
    first_f  = (mode_q == ModeIdFirst) || (mode_q == ModeNumFirst);
    kind     = is_id ? KindId : KindNum;
    close_ch = oq_q ? CharDquote : CharSquote;

    if (!skip_q) begin
      case (mode_q)
        ModeIdFirst, ModeIdMore, ModeNumFirst, ModeNumMore: begin
          if (!is_id && ch_i == CharDot && dot_q) begin
            items[n[IdxW-1:0]] = mk_item(8'd0, KindNone, 1'b0, 1'b0, ErrSecondDot);
            n = n + 1'b1;
            mode_d = ModeIdle;
            cnt_d  = 2'd0;
            skip_d = 1'b1;
          end else if (is_digit(ch_i) || (is_id && is_id_start(ch_i)) ||
                       (!is_id && ch_i == CharDot)) begin
            if (ch_i == CharDot) begin
              dot_d = 1'b1;
            end
            items[n[IdxW-1:0]] = mk_item(held0_q, kind, first_f, 1'b0, ErrNone);
            n = n + 1'b1;
            held0_d = ch_i;
            mode_d  = is_id ? ModeIdMore : ModeNumMore;
          end else begin
            items[n[IdxW-1:0]] = mk_item(held0_q, kind, first_f, 1'b1, ErrNone);
            n = n + 1'b1;
            mode_d   = ModeIdle;
            cnt_d    = 2'd0;
            do_start = 1'b1;
          end
        end
        ModeOp: begin
          if (cnt_q == 2'd2) begin
            // A held shift pair closes here, taking a trailing '=' with it.
            items[n[IdxW-1:0]] = mk_item(held0_q, KindOp, 1'b1, 1'b0, ErrNone);
            n = n + 1'b1;
            mode_d = ModeIdle;
            cnt_d  = 2'd0;
            if (ch_i == CharEq) begin
              items[n[IdxW-1:0]] = mk_item(held1_q, KindOp, 1'b0, 1'b0, ErrNone);
              n = n + 1'b1;
              items[n[IdxW-1:0]] = mk_item(ch_i, KindOp, 1'b0, 1'b1, ErrNone);
              n = n + 1'b1;
            end else begin
              items[n[IdxW-1:0]] = mk_item(held1_q, KindOp, 1'b0, 1'b1, ErrNone);
              n = n + 1'b1;
              do_start = 1'b1;
            end
          end else if (is_eq_op(held0_q) && ch_i == CharEq) begin
            items[n[IdxW-1:0]] = mk_item(held0_q, KindOp, 1'b1, 1'b0, ErrNone);
            n = n + 1'b1;
            items[n[IdxW-1:0]] = mk_item(ch_i, KindOp, 1'b0, 1'b1, ErrNone);
            n = n + 1'b1;
            mode_d = ModeIdle;
            cnt_d  = 2'd0;
          end else if ((held0_q inside {8'h3c, 8'h3e}) && ch_i == held0_q) begin
            held1_d = ch_i;
            cnt_d   = 2'd2;
          end else if ((held0_q inside {8'h2b, 8'h2d, 8'h26, 8'h7c}) &&
                       ch_i == held0_q) begin
            items[n[IdxW-1:0]] = mk_item(held0_q, KindOp, 1'b1, 1'b0, ErrNone);
            n = n + 1'b1;
            items[n[IdxW-1:0]] = mk_item(ch_i, KindOp, 1'b0, 1'b1, ErrNone);
            n = n + 1'b1;
            mode_d = ModeIdle;
            cnt_d  = 2'd0;
          end else begin
            items[n[IdxW-1:0]] = mk_item(held0_q, KindOp, 1'b1, 1'b1, ErrNone);
            n = n + 1'b1;
            mode_d   = ModeIdle;
            cnt_d    = 2'd0;
            do_start = 1'b1;
          end
        end
        ModeStr: begin
          if (ch_i == close_ch) begin
            depth_d = depth_q - 1'b1;
            oq_d    = !oq_q;
            if (depth_q == DepthW'(1)) begin
              items[n[IdxW-1:0]] = mk_item(ch_i, KindStr, 1'b0, 1'b1, ErrNone);
              n = n + 1'b1;
              mode_d = ModeIdle;
              cnt_d  = 2'd0;
            end else begin
              items[n[IdxW-1:0]] = mk_item(ch_i, KindStr, 1'b0, 1'b0, ErrNone);
              n = n + 1'b1;
            end
          end else if (ch_i == CharSquote || ch_i == CharDquote) begin
            if (depth_q >= DepthW'(MaxQuoteDepth)) begin
              items[n[IdxW-1:0]] = mk_item(8'd0, KindNone, 1'b0, 1'b0, ErrNestOverflow);
              n = n + 1'b1;
              mode_d = ModeIdle;
              cnt_d  = 2'd0;
              skip_d = 1'b1;
            end else begin
              depth_d = depth_q + 1'b1;
              oq_d    = !oq_q;
              items[n[IdxW-1:0]] = mk_item(ch_i, KindStr, 1'b0, 1'b0, ErrNone);
              n = n + 1'b1;
            end
          end else begin
            items[n[IdxW-1:0]] = mk_item(ch_i, KindStr, 1'b0, 1'b0, ErrNone);
            n = n + 1'b1;
          end
        end
        default: begin
          mode_d   = ModeIdle;
          cnt_d    = 2'd0;
          do_start = 1'b1;
        end
      endcase

      // Open a new token with the current character.
      if (do_start) begin
        if (is_id_start(ch_i)) begin
          held0_d = ch_i;
          cnt_d   = 2'd1;
          mode_d  = ModeIdFirst;
        end else if (is_digit(ch_i)) begin
          held0_d = ch_i;
          cnt_d   = 2'd1;
          mode_d  = ModeNumFirst;
          dot_d   = 1'b0;
        end else if (is_op(ch_i)) begin
          held0_d = ch_i;
          cnt_d   = 2'd1;
          mode_d  = ModeOp;
        end else if (ch_i == CharSquote || ch_i == CharDquote) begin
          items[n[IdxW-1:0]] = mk_item(ch_i, KindStr, 1'b1, 1'b0, ErrNone);
          n = n + 1'b1;
          mode_d  = ModeStr;
          depth_d = DepthW'(1);
          oq_d    = (ch_i == CharDquote);
        end
      end

      // At line end, close whatever token is still pending.
      if (line_end_i && !skip_d) begin
        case (mode_d)
          ModeIdFirst, ModeIdMore: begin
            items[n[IdxW-1:0]] = mk_item(held0_d, KindId, mode_d == ModeIdFirst, 1'b1,
                                         ErrNone);
            n = n + 1'b1;
          end
          ModeNumFirst, ModeNumMore: begin
            items[n[IdxW-1:0]] = mk_item(held0_d, KindNum, mode_d == ModeNumFirst, 1'b1,
                                         ErrNone);
            n = n + 1'b1;
          end
          ModeOp: begin
            if (cnt_d == 2'd2) begin
              items[n[IdxW-1:0]] = mk_item(held0_d, KindOp, 1'b1, 1'b0, ErrNone);
              n = n + 1'b1;
              items[n[IdxW-1:0]] = mk_item(held1_d, KindOp, 1'b0, 1'b1, ErrNone);
              n = n + 1'b1;
            end else begin
              items[n[IdxW-1:0]] = mk_item(held0_d, KindOp, 1'b1, 1'b1, ErrNone);
              n = n + 1'b1;
            end
          end
          ModeStr: begin
            items[n[IdxW-1:0]] = mk_item(8'd0, KindNone, 1'b0, 1'b0, ErrUnterminated);
            n = n + 1'b1;
          end
          default: begin
          end
        endcase
      end
    end

    // Line end: mark the final item and return to the reset state.
    if (line_end_i) begin
      if (n == '0) begin
        items[0] = mk_item(8'd0, KindNone, 1'b0, 1'b0, ErrNone);
        n = NumW'(1);
      end
      items[IdxW'(n - 1'b1)].line_done = 1'b1;
      mode_d  = ModeIdle;
      held0_d = 8'd0;
      held1_d = 8'd0;
      cnt_d   = 2'd0;
      dot_d   = 1'b0;
      depth_d = '0;
      oq_d    = 1'b0;
      skip_d  = 1'b0;
    end
  end

  // Push only characters that caused at least one result.
  always_comb begin
    push_o.valid           = accept && (n != '0);
    push_o.bundle.items    = items;
    push_o.bundle.last_idx = IdxW'(n - 1'b1);
  end

  // Mode and control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeIdle;
      cnt_q   <= 2'd0;
      dot_q   <= 1'b0;
      depth_q <= '0;
      oq_q    <= 1'b0;
      skip_q  <= 1'b0;
    end else if (accept) begin
      mode_q  <= mode_d;
      cnt_q   <= cnt_d;
      dot_q   <= dot_d;
      depth_q <= depth_d;
      oq_q    <= oq_d;
      skip_q  <= skip_d;
    end
  end

  // Held lookahead characters.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      held0_q <= held0_d;
      held1_q <= held1_d;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/ecl_queue.sv
// Short queue of result bundles between the lexer front and the output stage.
// Depends on ecl_pkg.
`default_nettype none

module ecl_queue (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire ecl_pkg::bundle_req_t push_i,
  output logic                      full_o,
  output ecl_pkg::bundle_req_t      head_o,
  input  wire logic                 pop_i
);
  import ecl_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  bundle_t         mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o       = (cnt_q == CntW'(QueueDepth));
  assign do_push      = push_i.valid && !full_o;
  assign do_pop       = pop_i && (cnt_q != '0);
  assign head_o.valid = (cnt_q != '0);
  assign head_o.bundle = mem_q[rd_ptr_q];

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Bundle storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.bundle;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/ecl_back.sv
// Output stage: walks each queued bundle, one item per cycle unless stalled.
// Depends on ecl_pkg.
`default_nettype none

module ecl_back (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire ecl_pkg::bundle_req_t head_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output ecl_pkg::item_t            item_o
);
  import ecl_pkg::*;

  localparam int unsigned IdxW = $clog2(MaxResults);

  logic [IdxW-1:0] idx_q, idx_d;
  logic            valid_q, valid_d;
  item_t           item_q;
  logic            load;

  // Load the next item whenever the output register is free or being drained.
  assign load  = head_i.valid && (!valid_q || out_ready_i);
  assign pop_o = load && (idx_q == head_i.bundle.last_idx);

  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
      idx_d   = pop_o ? '0 : idx_q + 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= head_i.bundle.items[idx_q];
    end
  end

  assign out_valid_o = valid_q;
  assign item_o      = item_q;

endmodule

`default_nettype wire

// File: hw/rtl/expression_char_lexer.sv
// Top level of the expression character lexer: front, bundle queue, output stage.
// Depends on ecl_pkg, ecl_front, ecl_queue and ecl_back.
//
//   Channel  Direction  Handshake                 Payload
//   input    in         in_valid_i / in_ready_o   ch_i, line_end_i
//   result   out        out_valid_o / out_ready_i tok_char_o, tok_kind_o, tok_first_o,
//                                                 tok_last_o, err_code_o, line_done_o
//
// The front takes one character per cycle while the queue is not full and turns it
// into zero to four results. The output register shows one result per cycle while
// the consumer keeps out_ready_i high; each result is loaded from the queue head into
// that register. A two-bundle queue lets the front keep accepting while results wait.
// Reset clears the mode and control state and empties the queue; held characters are not reset.
`default_nettype none

module expression_char_lexer #(
  parameter int unsigned MaxQuoteDepth = ecl_pkg::DefMaxQuoteDepth
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] ch_i,
  input  wire logic       line_end_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      tok_char_o,
  output logic [2:0]      tok_kind_o,
  output logic            tok_first_o,
  output logic            tok_last_o,
  output logic [1:0]      err_code_o,
  output logic            line_done_o
);
  import ecl_pkg::*;

  bundle_req_t push, head;
  logic        q_full, pop;
  item_t       item;

  ecl_front #(
    .MaxQuoteDepth(MaxQuoteDepth)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .ch_i       (ch_i),
    .line_end_i (line_end_i),
    .q_full_i   (q_full),
    .push_o     (push)
  );

  ecl_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (q_full),
    .head_o (head),
    .pop_i  (pop)
  );

  ecl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .item_o      (item)
  );

  assign tok_char_o  = item.tok_char;
  assign tok_kind_o  = item.tok_kind;
  assign tok_first_o = item.tok_first;
  assign tok_last_o  = item.tok_last;
  assign err_code_o  = item.err_code;
  assign line_done_o = item.line_done;

endmodule

`default_nettype wire

// File: hw/rtl/ecl_checker.sv
// Port-level checks for the expression character lexer, bound to the top level.
// Depends on ecl_pkg, expression_char_lexer_macros.svh and expression_char_lexer.
`default_nettype none

`include "expression_char_lexer_macros.svh"

module ecl_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [7:0] tok_char_o,
  input wire logic [2:0] tok_kind_o,
  input wire logic       tok_first_o,
  input wire logic       tok_last_o,
  input wire logic [1:0] err_code_o,
  input wire logic       line_done_o
);
  import ecl_pkg::*;

  logic [15:0] payload;
  logic        stalled;
  logic        is_marker;

  assign payload   = {tok_char_o, tok_kind_o, tok_first_o, tok_last_o, err_code_o,
                      line_done_o};
  assign stalled   = out_valid_o && !out_ready_i;
  assign is_marker = (tok_kind_o == KindNone);

  // A stalled result transaction keeps its valid.
  `ECL_ASSERT_NEXT(a_out_valid_held, stalled, out_valid_o, "valid dropped")

  // A stalled result transaction keeps its payload.
  `ECL_ASSERT_NEXT(a_out_data_held, stalled, $stable(payload), "payload changed")

  // Marker and error items carry no character and no token marks.
  `ECL_ASSERT_IMPL(a_marker_clean, out_valid_o && is_marker, payload[15:8] == 8'd0 && !tok_first_o && !tok_last_o, "marker item not clean")

  // Only marker items report an error.
  `ECL_ASSERT_IMPL(a_err_on_marker, out_valid_o && err_code_o != ErrNone, is_marker, "error on token item")

endmodule

bind expression_char_lexer ecl_checker u_ecl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .tok_char_o  (tok_char_o),
  .tok_kind_o  (tok_kind_o),
  .tok_first_o (tok_first_o),
  .tok_last_o  (tok_last_o),
  .err_code_o  (err_code_o),
  .line_done_o (line_done_o)
);

`default_nettype wire

// File: bench/ecl_lexer_checker.sv
`timescale 1ns / 1ps
// Checker for the expression character lexer: it watches both channels, works out
// the token stream from every accepted character and compares every accepted result.
// Depends on ecl_pkg.
module ecl_lexer_checker #(
  parameter int unsigned MaxQuoteDepth = ecl_pkg::DefMaxQuoteDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic [7:0] ch_i,
  input  logic       line_end_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic [7:0] tok_char_i,
  input  logic [2:0] tok_kind_i,
  input  logic       tok_first_i,
  input  logic       tok_last_i,
  input  logic [1:0] err_code_i,
  input  logic       line_done_i,
  output int         fail_count_o,
  output int         pending_o
);
  import ecl_pkg::*;

  // Tokenizer state kept alongside the block.
  lex_mode_e   tk_mode = ModeIdle;
  logic [7:0]  tk_held [2];
  logic [1:0]  tk_held_cnt = 2'd0;
  logic        tk_dot = 1'b0;
  int unsigned tk_depth = 0;
  logic        tk_dq = 1'b0;
  logic        tk_skip = 1'b0;

  // Results of the character being worked on, and all results still owed.
  item_t step_items[$];
  item_t expected_tokens[$];
  int    mismatches = 0;
  int    result_no = 0;

  // Character classes of the grammar.
  function automatic bit is_digit_ch(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_id_start_ch(logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
           c == CharUnderscore || c == CharDollar;
  endfunction

  function automatic bit is_eq_op_ch(logic [7:0] c);
    case (c)
      "+", "-", "*", "/", "%", "^", "|", "&", "=", "<", ">", "!": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit is_op_ch(logic [7:0] c);
    case (c)
      "~", ";", ",", ".", "(", ")", "[", "]", "{", "}": return 1'b1;
      default: return is_eq_op_ch(c);
    endcase
  endfunction

  // Appends one result for the current character; at most MaxResults are kept.
  function automatic void emit(logic [7:0] c, tok_kind_e kind, logic first, logic last,
                               err_e err);
    item_t it;
    if (step_items.size() < MaxResults) begin
      it.tok_char  = c;
      it.tok_kind  = kind;
      it.tok_first = first;
      it.tok_last  = last;
      it.err_code  = err;
      it.line_done = 1'b0;
      step_items.insert(step_items.size(), it);
    end
  endfunction

  function automatic void go_idle();
    tk_mode = ModeIdle;
    tk_held_cnt = 2'd0;
  endfunction

  function automatic void clear_state();
    go_idle();
    tk_held[0] = 8'h00;
    tk_held[1] = 8'h00;
    tk_dot = 1'b0;
    tk_depth = 0;
    tk_dq = 1'b0;
    tk_skip = 1'b0;
  endfunction

  // An error item ends the token and the rest of the line is ignored.
  function automatic void raise_error(err_e code);
    emit(8'h00, KindNone, 1'b0, 1'b0, code);
    go_idle();
    tk_skip = 1'b1;
  endfunction

  // Starts a token on a character seen while idle.
  function automatic void open_token(logic [7:0] c);
    if (is_id_start_ch(c)) begin
      tk_held[0] = c;
      tk_held_cnt = 2'd1;
      tk_mode = ModeIdFirst;
    end else if (is_digit_ch(c)) begin
      tk_held[0] = c;
      tk_held_cnt = 2'd1;
      tk_mode = ModeNumFirst;
      tk_dot = 1'b0;
    end else if (is_op_ch(c)) begin
      tk_held[0] = c;
      tk_held_cnt = 2'd1;
      tk_mode = ModeOp;
    end else if (c == CharSquote || c == CharDquote) begin
      emit(c, KindStr, 1'b1, 1'b0, ErrNone);
      tk_mode = ModeStr;
      tk_depth = 1;
      tk_dq = (c == CharDquote);
    end
  endfunction

  function automatic void lex_char(logic [7:0] c);
    logic [7:0] h;
    tok_kind_e  kind;
    logic       first;
    h = tk_held[0];
    case (tk_mode)
      ModeIdFirst, ModeIdMore, ModeNumFirst, ModeNumMore: begin
        if (tk_mode == ModeIdFirst || tk_mode == ModeIdMore) kind = KindId;
        else kind = KindNum;
        first = (tk_mode == ModeIdFirst || tk_mode == ModeNumFirst);
        if (kind == KindNum && c == CharDot && tk_dot) begin
          raise_error(ErrSecondDot);
        end else if (is_digit_ch(c) || (kind == KindId && is_id_start_ch(c)) ||
                     (kind == KindNum && c == CharDot)) begin
          if (c == CharDot) tk_dot = 1'b1;
          emit(h, kind, first, 1'b0, ErrNone);
          tk_held[0] = c;
          if (kind == KindId) tk_mode = ModeIdMore;
          else tk_mode = ModeNumMore;
        end else begin
          emit(h, kind, first, 1'b1, ErrNone);
          go_idle();
          open_token(c);
        end
      end
      ModeOp: begin
        if (tk_held_cnt == 2'd2) begin
          // A held shift pair either takes '=' or closes as a two-character operator.
          emit(h, KindOp, 1'b1, 1'b0, ErrNone);
          if (c == CharEq) begin
            emit(tk_held[1], KindOp, 1'b0, 1'b0, ErrNone);
            emit(c, KindOp, 1'b0, 1'b1, ErrNone);
            go_idle();
          end else begin
            emit(tk_held[1], KindOp, 1'b0, 1'b1, ErrNone);
            go_idle();
            open_token(c);
          end
        end else if (is_eq_op_ch(h) && c == CharEq) begin
          emit(h, KindOp, 1'b1, 1'b0, ErrNone);
          emit(c, KindOp, 1'b0, 1'b1, ErrNone);
          go_idle();
        end else if ((h == "<" || h == ">") && c == h) begin
          tk_held[1] = c;
          tk_held_cnt = 2'd2;
        end else if ((h == "+" || h == "-" || h == "&" || h == "|") && c == h) begin
          emit(h, KindOp, 1'b1, 1'b0, ErrNone);
          emit(c, KindOp, 1'b0, 1'b1, ErrNone);
          go_idle();
        end else begin
          emit(h, KindOp, 1'b1, 1'b1, ErrNone);
          go_idle();
          open_token(c);
        end
      end
      ModeStr: begin
        // The innermost quote type closes a level; the other type opens one.
        if (c == (tk_dq ? CharDquote : CharSquote)) begin
          tk_depth--;
          tk_dq = ~tk_dq;
          if (tk_depth == 0) begin
            emit(c, KindStr, 1'b0, 1'b1, ErrNone);
            go_idle();
          end else begin
            emit(c, KindStr, 1'b0, 1'b0, ErrNone);
          end
        end else if (c == CharSquote || c == CharDquote) begin
          if (tk_depth >= MaxQuoteDepth) begin
            raise_error(ErrNestOverflow);
          end else begin
            tk_depth++;
            tk_dq = ~tk_dq;
            emit(c, KindStr, 1'b0, 1'b0, ErrNone);
          end
        end else begin
          emit(c, KindStr, 1'b0, 1'b0, ErrNone);
        end
      end
      default: begin
        go_idle();
        open_token(c);
      end
    endcase
  endfunction

  // Closes whatever is pending when the line ends.
  function automatic void flush_line();
    logic [7:0] h;
    h = tk_held[0];
    case (tk_mode)
      ModeIdFirst, ModeIdMore: emit(h, KindId, tk_mode == ModeIdFirst, 1'b1, ErrNone);
      ModeNumFirst, ModeNumMore: emit(h, KindNum, tk_mode == ModeNumFirst, 1'b1, ErrNone);
      ModeOp: begin
        if (tk_held_cnt == 2'd2) begin
          emit(h, KindOp, 1'b1, 1'b0, ErrNone);
          emit(tk_held[1], KindOp, 1'b0, 1'b1, ErrNone);
        end else begin
          emit(h, KindOp, 1'b1, 1'b1, ErrNone);
        end
      end
      ModeStr: emit(8'h00, KindNone, 1'b0, 1'b0, ErrUnterminated);
      default: ;
    endcase
  endfunction

  function automatic void predict_char(logic [7:0] c, logic eol);
    step_items.delete();
    if (!tk_skip) lex_char(c);
    if (eol) begin
      if (!tk_skip) flush_line();
      // A line that produced nothing still reports its end with a marker.
      if (step_items.size() == 0) emit(8'h00, KindNone, 1'b0, 1'b0, ErrNone);
      step_items[step_items.size() - 1].line_done = 1'b1;
      clear_state();
    end
    foreach (step_items[i]) expected_tokens.insert(expected_tokens.size(), step_items[i]);
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] lexer mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_result();
    item_t want;
    string bad;
    result_no++;
    if (expected_tokens.size() == 0) begin
      report_mismatch($sformatf("result %0d arrived with nothing owed (char %02h kind %0d)",
                                result_no, tok_char_i, tok_kind_i));
    end else begin
      want = expected_tokens.pop_front();
      bad = "";
      if (tok_char_i !== want.tok_char) bad = {bad, " tok_char"};
      if (tok_kind_i !== want.tok_kind) bad = {bad, " tok_kind"};
      if (tok_first_i !== want.tok_first) bad = {bad, " tok_first"};
      if (tok_last_i !== want.tok_last) bad = {bad, " tok_last"};
      if (err_code_i !== want.err_code) bad = {bad, " err_code"};
      if (line_done_i !== want.line_done) bad = {bad, " line_done"};
      if (bad != "") begin
        report_mismatch($sformatf(
          "result %0d,%s: got %02h/%0d/%b/%b/%0d/%b want %02h/%0d/%b/%b/%0d/%b",
          result_no, bad, tok_char_i, tok_kind_i, tok_first_i, tok_last_i, err_code_i,
          line_done_i, want.tok_char, want.tok_kind, want.tok_first, want.tok_last,
          want.err_code, want.line_done));
      end
    end
  endtask

  // Predict on every accepted character, then check every accepted result.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_state();
      expected_tokens.delete();
      pending_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i) predict_char(ch_i, line_end_i);
      if (out_valid_i && out_ready_i) check_result();
      pending_o <= expected_tokens.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

// File: bench/tb_expression_char_lexer.sv
`timescale 1ns / 1ps
// Testbench top for expression_char_lexer: feeds directed and random character lines
// with random pacing on both sides and gives the verdict from the checker's count.
// Depends on ecl_pkg, the lexer RTL and ecl_lexer_checker.
module tb_expression_char_lexer;
  import ecl_pkg::*;

  localparam int unsigned MaxQuoteDepth = DefMaxQuoteDepth;
  localparam int TargetChars  = 350;
  localparam int RxHoldCycles = 80;
  localparam int QuietLimit   = 1000;
  localparam int DrainCycles  = 20;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic [7:0] ch = 8'h00;
  logic       line_end = 1'b0;
  logic       out_ready = 1'b0;
  logic       in_ready;
  logic       out_valid;
  logic [7:0] tok_char;
  logic [2:0] tok_kind;
  logic       tok_first;
  logic       tok_last;
  logic [1:0] err_code;
  logic       line_done;
  int         fail_count;
  int         pending_results;

  // Pacing controls and the line being assembled.
  bit         tx_idle_en = 1'b1;
  bit         rx_idle_en = 1'b1;
  int         hold_requests = 0;
  logic [7:0] line_buf[$];
  int         token_chars = 0;
  string      single_ops = "+-*/%^|&=<>!~;,.()[]{}";
  string      eq_ops = "+-*/%^|&=<>!";
  string      double_ops = "+-<>&|";

  always #4 clk = ~clk;

  expression_char_lexer #(
    .MaxQuoteDepth(MaxQuoteDepth)
  ) uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .ch_i       (ch),
    .line_end_i (line_end),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .tok_char_o (tok_char),
    .tok_kind_o (tok_kind),
    .tok_first_o(tok_first),
    .tok_last_o (tok_last),
    .err_code_o (err_code),
    .line_done_o(line_done)
  );

  ecl_lexer_checker #(
    .MaxQuoteDepth(MaxQuoteDepth)
  ) u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .ch_i        (ch),
    .line_end_i  (line_end),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .tok_char_i  (tok_char),
    .tok_kind_i  (tok_kind),
    .tok_first_i (tok_first),
    .tok_last_i  (tok_last),
    .err_code_i  (err_code),
    .line_done_i (line_done),
    .fail_count_o(fail_count),
    .pending_o   (pending_results)
  );

  // One character transaction; valid stays high across back-to-back transactions.
  task automatic send_char(input logic [7:0] c, input logic eol);
    int gap;
    gap = tx_idle_en ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    ch <= c;
    line_end <= eol;
    do begin
      @(posedge clk);
    end while (!in_ready);
  endtask

  task automatic send_line();
    foreach (line_buf[i]) send_char(line_buf[i], i == line_buf.size() - 1);
    line_buf.delete();
  endtask

  // Stops offering characters until every owed result has been taken.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do begin
      @(posedge clk);
    end while (pending_results != 0);
  endtask

  // Line builders: every character placed in a line is counted.
  function automatic void add_raw(logic [7:0] c);
    line_buf.insert(line_buf.size(), c);
    token_chars++;
  endfunction

  function automatic void add_tok(logic [7:0] c);
    line_buf.insert(line_buf.size(), c);
    token_chars++;
  endfunction

  function automatic void add_str(string s);
    for (int i = 0; i < s.len(); i++) add_tok(s[i]);
  endfunction

  function automatic logic [7:0] rand_id_char(bit with_digits);
    int r;
    r = $urandom_range(0, with_digits ? 63 : 53);
    if (r < 26) return 8'(8'h41 + r);
    if (r < 52) return 8'(8'h61 + r - 26);
    if (r == 52) return CharUnderscore;
    if (r == 53) return CharDollar;
    return 8'(8'h30 + r - 54);
  endfunction

  function automatic void add_ident();
    add_tok(rand_id_char(1'b0));
    repeat ($urandom_range(0, 5)) add_tok(rand_id_char(1'b1));
  endfunction

  function automatic void add_digits(int n);
    repeat (n) add_tok(8'(8'h30 + $urandom_range(0, 9)));
  endfunction

  // Mostly well-formed numbers; now and then a second dot.
  function automatic void add_number();
    add_digits($urandom_range(1, 4));
    if ($urandom_range(0, 1)) begin
      add_tok(CharDot);
      add_digits($urandom_range(0, 3));
      if ($urandom_range(0, 5) == 0) begin
        add_tok(CharDot);
        add_digits($urandom_range(0, 2));
      end
    end
  endfunction

  function automatic void add_operator();
    logic [7:0] c;
    case ($urandom_range(0, 3))
      0: add_tok(single_ops[$urandom_range(0, single_ops.len() - 1)]);
      1: begin
        add_tok(eq_ops[$urandom_range(0, eq_ops.len() - 1)]);
        add_tok(CharEq);
      end
      2: begin
        c = $urandom_range(0, 1) ? "<" : ">";
        add_tok(c);
        add_tok(c);
        add_tok(CharEq);
      end
      default: begin
        c = double_ops[$urandom_range(0, double_ops.len() - 1)];
        add_tok(c);
        add_tok(c);
      end
    endcase
  endfunction

  function automatic void add_string_body();
    logic [7:0] c;
    repeat ($urandom_range(0, 3)) begin
      do begin
        c = 8'($urandom_range(0, 255));
      end while (c == CharSquote || c == CharDquote);
      add_tok(c);
    end
  endfunction

  // Nested string literal: quotes alternate on the way in and close in reverse order.
  function automatic void add_string_lit(int depth, bit closed);
    logic [7:0] opens[$];
    logic [7:0] q;
    q = $urandom_range(0, 1) ? CharDquote : CharSquote;
    for (int i = 0; i < depth; i++) begin
      opens.insert(opens.size(), q);
      add_tok(q);
      add_string_body();
      q = (q == CharDquote) ? CharSquote : CharDquote;
    end
    if (closed) begin
      while (opens.size() > 0) begin
        add_tok(opens.pop_back());
        if (opens.size() > 0) add_string_body();
      end
    end
  endfunction

  // Most lines are token sequences; a few are noise or nearly empty.
  function automatic void build_random_line();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel == 0) begin
      repeat ($urandom_range(1, 8)) add_raw(8'($urandom_range(0, 255)));
    end else if (sel == 1) begin
      add_raw(" ");
    end else begin
      repeat ($urandom_range(1, 6)) begin
        case ($urandom_range(0, 9))
          0, 1, 2: add_ident();
          3, 4: add_number();
          5, 6, 7: add_operator();
          8: add_string_lit($urandom_range(1, 3), $urandom_range(0, 7) != 0);
          default: add_raw(8'($urandom_range(0, 255)));
        endcase
        if ($urandom_range(0, 2) == 0) add_raw(" ");
      end
    end
  endfunction

  // Result side: random stalls per transaction, plus a long hold-off on request.
  initial begin : result_sink
    int gap;
    int holds_done;
    holds_done = 0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_requests != holds_done) begin
        holds_done = hold_requests;
        gap = RxHoldCycles;
      end else begin
        gap = rx_idle_en ? $urandom_range(0, 5) : 0;
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do begin
        @(posedge clk);
      end while (!out_valid);
    end
  end

  // Ends the run if neither channel moves for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    int lines;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed lines: identifier, shift assign and fraction in one line.
    add_str("x$_9<<=1.5");
    send_line();
    // Number with a second dot on the final character.
    add_str("1.2.");
    send_line();
    // Nested string with both quote types.
    add_str("'a\"\"'");
    send_line();
    // String still open at the end of the line.
    add_str("\"b");
    send_line();
    // Doubled operator, then a shift pair closed by the end of the line.
    add_str("&&>>");
    send_line();
    // Lines holding only a skipped byte at either end of the range.
    add_raw(8'h00);
    send_line();
    add_raw(8'hff);
    send_line();
    wait_drained();

    // Quote nesting right at the bound, then one level beyond it.
    add_string_lit(MaxQuoteDepth, 1'b1);
    send_line();
    add_ident();
    add_string_lit(MaxQuoteDepth + 1, 1'b1);
    add_raw(" ");
    add_ident();
    send_line();
    wait_drained();

    // Back-pressure: the result side holds off while characters keep coming.
    tx_idle_en = 1'b0;
    hold_requests <= hold_requests + 1;
    repeat (10) begin
      add_operator();
      add_ident();
    end
    send_line();
    wait_drained();

    // Random lines, cycling through the pacing combinations.
    lines = 0;
    while (token_chars < TargetChars) begin
      case ((lines / 10) % 4)
        0: begin
          tx_idle_en = 1'b1;
          rx_idle_en <= 1'b1;
        end
        1: begin
          tx_idle_en = 1'b0;
          rx_idle_en <= 1'b0;
        end
        2: begin
          tx_idle_en = 1'b1;
          rx_idle_en <= 1'b0;
        end
        default: begin
          tx_idle_en = 1'b0;
          rx_idle_en <= 1'b1;
        end
      endcase
      build_random_line();
      send_line();
      lines++;
      if ($urandom_range(0, 7) == 0) wait_drained();
    end

    wait_drained();
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
